FILE: src/assert_macros.svh
// Assertion macros shared by the receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/frc_pkg.sv
// Types, codes and the CRC16 update for the frame receiver
package frc_pkg;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_OK       = 2'd1;
  localparam logic [1:0] KIND_CRC_ERR  = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd3;

  localparam logic [1:0] STEP_ADDR     = 2'd0;
  localparam logic [1:0] STEP_OPTION   = 2'd1;
  localparam logic [1:0] STEP_LENGTH   = 2'd2;
  localparam logic [1:0] STEP_PAYLOAD  = 2'd3;

  localparam logic [1:0] REG_ADDRESS   = 2'd0;
  localparam logic [1:0] REG_OPTION    = 2'd1;
  localparam logic [1:0] REG_CHECK     = 2'd2;
  localparam logic [1:0] REG_TIMEOUT   = 2'd3;

  localparam logic       OP_BYTE       = 1'b0;
  localparam logic       OP_TICK       = 1'b1;

  localparam logic [7:0]  ADDRESS_RESET = 8'h5A;
  localparam logic [7:0]  OPTION_RESET  = 8'hA5;
  localparam logic [3:0]  TIMEOUT_RESET = 4'd2;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_count;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: src/frame_receiver_crc16_check_top.sv
// Top level of the serial frame receiver with CRC16 check
// Input stream: one beat per received byte (s_tuser 0) or idle poll tick (s_tuser 1).
// Configuration: a write on cfg_valid/cfg_ready sets address, option, check enable
// and timeout by index 0 to 3; write only while the receiver is idle.
// Output stream: one beat per data byte or frame status; m_tuser gives the kind,
// m_tdata the data byte and the running data count, m_tlast the last beat of a byte.
// Each result is registered in the queue and then in the output register.
// Throughput: one input beat per cycle while s_tready is high; a frame-ending data
// byte yields two output beats, so sustained rate is set by the single output
// register draining the queue. Each beat and its CRC16 update are handled combinationally.
// Reset: configuration returns to its defaults, the receiver hunts for an address
// and the result queue empties; s_tready and cfg_ready are low during reset.
// Stall: while m_tready is low results collect in the queue; s_tready drops when
// fewer than two queue slots are free and rises again as beats drain.
module frame_receiver_crc16_check_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_byte, [15:8] byte_count
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  frc_pkg::push_t   push;
  frc_pkg::result_t head;
  logic             not_empty;
  logic             room;
  logic             pop;
  logic             fire;

  assign cfg_ready = !rst;
  assign s_tready  = room && !rst;
  assign fire      = s_tvalid && s_tready;

  frc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .op        (s_tuser),
    .rx_byte   (s_tdata),
    .push      (push)
  );

  frc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  frc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: src/frc_front.sv
// Front end: configuration registers, frame hunting, CRC and result generation
`include "assert_macros.svh"

module frc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 fire,
  input  logic                 op,
  input  logic [7:0]           rx_byte,
  output frc_pkg::push_t       push
);

  logic [7:0]  frame_address;
  logic [7:0]  frame_option;
  logic        check_enable;
  logic [3:0]  timeout_ticks;

  logic [1:0]  hunt_step, hunt_step_next;
  logic        frame_active, frame_active_next;
  logic [7:0]  declared_length, declared_length_next;
  logic [7:0]  received_count, received_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [3:0]  idle_ticks, idle_ticks_next;

  logic [1:0]  hs_eff;
  logic [7:0]  rc_eff;
  logic [3:0]  it_eff;
  logic [4:0]  tick_sum;
  logic [8:0]  idx;
  logic [7:0]  len_m2, len_lim, so_far;
  logic [15:0] crc_base, crc_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_address <= frc_pkg::ADDRESS_RESET;
      frame_option  <= frc_pkg::OPTION_RESET;
      check_enable  <= 1'b0;
      timeout_ticks <= frc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        frc_pkg::REG_ADDRESS: frame_address <= cfg_data;
        frc_pkg::REG_OPTION:  frame_option  <= cfg_data;
        frc_pkg::REG_CHECK:   check_enable  <= cfg_data[0];
        frc_pkg::REG_TIMEOUT: timeout_ticks <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hs_eff   = frame_active ? hunt_step : frc_pkg::STEP_ADDR;
    rc_eff   = frame_active ? received_count : 8'd0;
    it_eff   = frame_active ? idle_ticks : 4'd0;
    tick_sum = {1'b0, it_eff} + 5'd1;
    idx      = {1'b0, rc_eff} + 9'd1;
    len_m2   = declared_length - 8'd2;
    len_lim  = (declared_length >= 8'd2) ? len_m2 : 8'd0;
    so_far   = (check_enable && (rc_eff > len_lim)) ? len_lim : rc_eff;
    crc_base = (hs_eff == frc_pkg::STEP_ADDR) ? frc_pkg::CRC_INIT : running_crc;
    crc_upd  = frc_pkg::crc_add(crc_base, rx_byte);
  end

  always_comb begin
    hunt_step_next       = hunt_step;
    frame_active_next    = frame_active;
    declared_length_next = declared_length;
    received_count_next  = received_count;
    running_crc_next     = running_crc;
    held_byte_next       = held_byte;
    idle_ticks_next      = idle_ticks;
    push                 = '0;
    if (fire) begin
      hunt_step_next      = hs_eff;
      received_count_next = rc_eff;
      idle_ticks_next     = it_eff;
      if (op == frc_pkg::OP_TICK) begin
        if (frame_active) begin
          if (tick_sum > {1'b0, timeout_ticks}) begin
            frame_active_next   = 1'b0;
            hunt_step_next      = frc_pkg::STEP_ADDR;
            received_count_next = 8'd0;
            idle_ticks_next     = 4'd0;
            push.count          = 2'd1;
            push.first          = '{kind: frc_pkg::KIND_TIMEOUT, data_byte: 8'd0,
                                    byte_count: so_far, last: 1'b1};
          end else begin
            idle_ticks_next = tick_sum[3:0];
          end
        end
      end else begin
        idle_ticks_next = 4'd0;
        case (hs_eff)
          frc_pkg::STEP_ADDR: begin
            if (rx_byte == frame_address) begin
              frame_active_next   = 1'b1;
              received_count_next = 8'd0;
              running_crc_next    = crc_upd;
              hunt_step_next      = frc_pkg::STEP_OPTION;
            end
          end
          frc_pkg::STEP_OPTION: begin
            if (rx_byte == frame_option) begin
              running_crc_next = crc_upd;
              hunt_step_next   = frc_pkg::STEP_LENGTH;
            end else begin
              hunt_step_next = frc_pkg::STEP_ADDR;
            end
          end
          frc_pkg::STEP_LENGTH: begin
            if (rx_byte != 8'd0) begin
              declared_length_next = rx_byte;
              running_crc_next     = crc_upd;
              received_count_next  = 8'd0;
              hunt_step_next       = frc_pkg::STEP_PAYLOAD;
            end else begin
              hunt_step_next = frc_pkg::STEP_ADDR;
            end
          end
          default: begin
            received_count_next = idx[7:0];
            if (!check_enable) begin
              push.first = '{kind: frc_pkg::KIND_DATA, data_byte: rx_byte,
                             byte_count: idx[7:0], last: 1'b1};
              push.count = 2'd1;
              if (idx >= {1'b0, declared_length}) begin
                push.first.last     = 1'b0;
                push.second         = '{kind: frc_pkg::KIND_OK, data_byte: 8'd0,
                                        byte_count: idx[7:0], last: 1'b1};
                push.count          = 2'd2;
                frame_active_next   = 1'b0;
                hunt_step_next      = frc_pkg::STEP_ADDR;
                received_count_next = 8'd0;
              end
            end else if (declared_length < 8'd2) begin
              frame_active_next   = 1'b0;
              hunt_step_next      = frc_pkg::STEP_ADDR;
              received_count_next = 8'd0;
              push.count          = 2'd1;
              push.first          = '{kind: frc_pkg::KIND_CRC_ERR, data_byte: 8'd0,
                                      byte_count: 8'd0, last: 1'b1};
            end else if (idx <= {1'b0, len_m2}) begin
              running_crc_next = crc_upd;
              push.count       = 2'd1;
              push.first       = '{kind: frc_pkg::KIND_DATA, data_byte: rx_byte,
                                   byte_count: idx[7:0], last: 1'b1};
            end else if (idx == {1'b0, declared_length - 8'd1}) begin
              held_byte_next = rx_byte;
            end else begin
              frame_active_next   = 1'b0;
              hunt_step_next      = frc_pkg::STEP_ADDR;
              received_count_next = 8'd0;
              push.count          = 2'd1;
              push.first          = '{kind: ({rx_byte, held_byte} == running_crc) ?
                                            frc_pkg::KIND_OK : frc_pkg::KIND_CRC_ERR,
                                      data_byte: 8'd0, byte_count: len_m2, last: 1'b1};
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_step       <= frc_pkg::STEP_ADDR;
      frame_active    <= 1'b0;
      declared_length <= 8'd0;
      received_count  <= 8'd0;
      running_crc     <= frc_pkg::CRC_INIT;
      held_byte       <= 8'd0;
      idle_ticks      <= 4'd0;
    end else begin
      hunt_step       <= hunt_step_next;
      frame_active    <= frame_active_next;
      declared_length <= declared_length_next;
      received_count  <= received_count_next;
      running_crc     <= running_crc_next;
      held_byte       <= held_byte_next;
      idle_ticks      <= idle_ticks_next;
    end
  end

  `ASSERT_IMPLIES(a_hunt_in_frame, hunt_step != frc_pkg::STEP_ADDR, frame_active, "hunt step advanced outside a frame")
  `ASSERT_IMPLIES(a_pair_order, push.count == 2'd2, push.second.last && !push.first.last, "two-beat result not ordered data then status")

endmodule

FILE: src/frc_queue.sv
// Result queue between front and back, taking up to two beats a cycle
`include "assert_macros.svh"

module frc_queue #(
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  frc_pkg::push_t   push,
  input  logic             pop,
  output frc_pkg::result_t head,
  output logic             not_empty,
  output logic             room
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  frc_pkg::result_t entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic [PtrW-1:0]  wr_second;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_second = ptr_inc(wr_ptr);
  assign head      = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign room      = (count <= CntW'(Depth - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_second] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.count)
        2'd1:    wr_ptr <= wr_second;
        2'd2:    wr_ptr <= ptr_inc(wr_second);
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CntW'(push.count) - CntW'(pop);
    end
  end

  `ASSERT_HOLDS(a_count_bound, count <= CntW'(Depth), "queue count above depth")
  `ASSERT_IMPLIES(a_pop_nonempty, pop, count != '0, "pop from empty queue")
  `ASSERT_IMPLIES(a_push_room, push.count != 2'd0, count <= CntW'(Depth) - CntW'(push.count), "push overflows queue")

endmodule

FILE: src/frc_back.sv
// Back end: output register that drains the queue onto the result stream
module frc_back (
  input  logic             clk,
  input  logic             rst,
  input  frc_pkg::result_t head,
  input  logic             not_empty,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  assign pop = not_empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {head.byte_count, head.data_byte};
      m_tuser <= head.kind;
      m_tlast <= head.last;
    end
  end

endmodule
